// ----- sv/eft_pkg.sv -----
// ----------------------------------------------------------------------------
// eft_pkg: shared types and constants for the env file tokenizer
// Parse modes, result kinds, character codes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package eft_pkg;

  // width of the line number as seen on the result port
  localparam int unsigned LINE_OUT_W = 16;

  // input operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // parse modes
  typedef enum logic [3:0] {
    M_PREKEY  = 4'd0,
    M_KEY     = 4'd1,
    M_PREVAL  = 4'd2,
    M_VAL     = 4'd3,
    M_VALESC  = 4'd4,
    M_SQ      = 4'd5,
    M_DQ      = 4'd6,
    M_DQESC   = 4'd7,
    M_COMMENT = 4'd8,
    M_COMMESC = 4'd9
  } mode_t;

  // result kinds
  typedef enum logic [2:0] {
    K_KEY_CHAR  = 3'd0,
    K_VAL_CHAR  = 3'd1,
    K_PAIR_END  = 3'd2,
    K_KEY_DROP  = 3'd3,
    K_INPUT_END = 3'd4
  } kind_t;

  // controller states
  typedef enum logic [1:0] {
    C_IDLE  = 2'd0,
    C_FLUSH = 2'd1,
    C_TAIL0 = 2'd2,
    C_TAIL1 = 2'd3
  } ctrl_state_t;

  // which pending result goes to the output register
  typedef enum logic [1:0] {
    SEL_FLUSH = 2'd0,
    SEL_T0    = 2'd1,
    SEL_T1    = 2'd2
  } emit_sel_t;

  // controller to datapath
  typedef struct packed {
    logic      load;   // accept the input word and latch its plan
    logic      emit;   // load the output register
    emit_sel_t sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic plan_flush;  // plan of the offered word has held whitespace to emit
    logic plan_tail;   // plan of the offered word has at least one tail result
    logic fcnt_one;    // one flushed whitespace left
    logic tail_nz;     // latched plan has a tail result
    logic tail_two;    // latched plan has two tail results
    logic out_free;    // output register can take a word
  } sts_t;

  function automatic logic is_nl(input logic [7:0] c);
    return c inside {CH_LF, CH_CR};
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
  endfunction

endpackage

`default_nettype wire

// ----- sv/env_file_tokenizer.sv -----
// A word that causes results has its plan latched when it is taken, and each result then
// goes through the output register when it is free. Throughput: one word per cycle when
// it causes no result; else the next word waits until all its results (held whitespace
// flushed, then up to two more) are emitted, paced by the single output register and its stall.
// Reset: synchronous, active low; parse mode pre-key, line count one, store empty.
// ----------------------------------------------------------------------------
// env_file_tokenizer: byte-serial tokenizer for shell-style KEY=VALUE files
// Comments, quoting, backslash escapes and a bounded trailing whitespace
// store; key and value characters come out one word at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module env_file_tokenizer #(
  parameter int unsigned PENDING_WS_MAX = 32,
  parameter int unsigned LINE_BITS      = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_operation,
  input  wire logic [7:0]  in_ch,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_char,
  output logic [15:0]      out_line_number,
  output logic             out_ws_overflow,
  output logic             out_last
);

  eft_pkg::cmd_t cmd;
  eft_pkg::sts_t sts;

  // sequencer
  eft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // parse state and result path
  eft_dpath #(
    .PENDING_WS_MAX (PENDING_WS_MAX),
    .LINE_BITS      (LINE_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_operation    (in_operation),
    .in_ch           (in_ch),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_char        (out_char),
    .out_line_number (out_line_number),
    .out_ws_overflow (out_ws_overflow),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

// ----- sv/eft_ctrl.sv -----
// ----------------------------------------------------------------------------
// eft_ctrl: result sequencer for the env file tokenizer
// Takes one input word when idle, then steps through the held whitespace
// flush and up to two tail results, one per free output slot.
// ----------------------------------------------------------------------------
`default_nettype none

module eft_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire eft_pkg::sts_t sts,
  output eft_pkg::cmd_t      cmd
);

  eft_pkg::ctrl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= eft_pkg::C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.emit  = 1'b0;
    cmd.sel   = eft_pkg::SEL_FLUSH;
    in_stall  = 1'b1;
    case (state_r)
      eft_pkg::C_IDLE: begin
        // no word is taken while reset is held
        in_stall = !rst_n;
        if (in_valid && rst_n) begin
          cmd.load = 1'b1;
          if (sts.plan_flush) begin
            state_nxt = eft_pkg::C_FLUSH;
          end else if (sts.plan_tail) begin
            state_nxt = eft_pkg::C_TAIL0;
          end
        end
      end
      eft_pkg::C_FLUSH: begin
        cmd.sel = eft_pkg::SEL_FLUSH;
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.fcnt_one) begin
            state_nxt = sts.tail_nz ? eft_pkg::C_TAIL0 : eft_pkg::C_IDLE;
          end
        end
      end
      eft_pkg::C_TAIL0: begin
        cmd.sel = eft_pkg::SEL_T0;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.tail_two ? eft_pkg::C_TAIL1 : eft_pkg::C_IDLE;
        end
      end
      eft_pkg::C_TAIL1: begin
        cmd.sel = eft_pkg::SEL_T1;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = eft_pkg::C_IDLE;
        end
      end
      default: begin
        state_nxt = eft_pkg::C_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/eft_dpath.sv -----
// ----------------------------------------------------------------------------
// eft_dpath: parse state, pending whitespace store and output register
// Decodes each input word against the parse mode into a result plan, updates
// the parse state at once and holds the plan until the controller drains it.
// ----------------------------------------------------------------------------
`default_nettype none

module eft_dpath #(
  parameter int unsigned PENDING_WS_MAX = 32,
  parameter int unsigned LINE_BITS      = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_operation,
  input  wire logic [7:0]                    in_ch,
  input  wire eft_pkg::cmd_t                 cmd,
  output eft_pkg::sts_t                      sts,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [2:0]                         out_kind,
  output logic [7:0]                         out_char,
  output logic [eft_pkg::LINE_OUT_W-1:0]     out_line_number,
  output logic                               out_ws_overflow,
  output logic                               out_last
);

  localparam int unsigned PCW = $clog2(PENDING_WS_MAX + 1);
  localparam logic [PCW-1:0]       PMAX     = PCW'(PENDING_WS_MAX);
  localparam logic [LINE_BITS-1:0] LINE_TOP = '1;
  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

  // parse state
  eft_pkg::mode_t              mode_r, mode_nxt;
  logic [LINE_BITS-1:0]        line_r, line_nxt;
  logic [PCW-1:0]              pcnt_r, pcnt_nxt;
  logic [PENDING_WS_MAX-1:0]   ptab_r, ptab_nxt;
  logic                        ovf_r, ovf_nxt;

  // latched plan of the word being drained
  logic [LINE_BITS-1:0]        snap_line_r;
  logic                        snap_ovf_r;
  logic [PCW-1:0]              fcnt_r;
  logic [PENDING_WS_MAX-1:0]   ftab_r;
  eft_pkg::kind_t              fkind_r;
  logic [1:0]                  ntail_r;
  eft_pkg::kind_t              t0_kind_r, t1_kind_r;
  logic [7:0]                  t0_char_r, t1_char_r;
  logic                        t0_ovf_r, t1_ovf_r;

  // plan of the offered word
  logic                        p_flush;
  eft_pkg::kind_t              p_fkind;
  logic [1:0]                  p_ntail;
  eft_pkg::kind_t              p_t0_kind, p_t1_kind;
  logic [7:0]                  p_t0_char, p_t1_char;
  logic                        p_t1_ovf;

  // output register
  logic                        out_valid_r;
  eft_pkg::kind_t              o_kind_r;
  logic [7:0]                  o_char_r;
  logic [LINE_BITS-1:0]        o_line_r;
  logic                        o_ovf_r;
  logic                        o_last_r;

  logic                        out_free;
  logic [LINE_BITS-1:0]        line_inc;

  assign out_free = !out_valid_r || !out_stall;
  assign line_inc = (line_r != LINE_TOP) ? line_r + LINE_ONE : line_r;

  // decode the offered word against the current mode
  always_comb begin
    logic [7:0] c;
    c         = in_ch;
    mode_nxt  = mode_r;
    line_nxt  = line_r;
    pcnt_nxt  = pcnt_r;
    ptab_nxt  = ptab_r;
    ovf_nxt   = ovf_r;
    p_flush   = 1'b0;
    p_fkind   = eft_pkg::K_KEY_CHAR;
    p_ntail   = 2'd0;
    p_t0_kind = eft_pkg::K_KEY_CHAR;
    p_t0_char = eft_pkg::CH_NUL;
    p_t1_kind = eft_pkg::K_INPUT_END;
    p_t1_char = eft_pkg::CH_NUL;
    p_t1_ovf  = ovf_r;
    if (in_operation == eft_pkg::OP_END) begin
      // close what is open, then end of input and back to reset values
      p_t1_ovf = 1'b0;
      case (mode_r)
        eft_pkg::M_PREVAL, eft_pkg::M_VAL, eft_pkg::M_VALESC,
        eft_pkg::M_SQ, eft_pkg::M_DQ, eft_pkg::M_DQESC: begin
          p_ntail   = 2'd2;
          p_t0_kind = eft_pkg::K_PAIR_END;
        end
        eft_pkg::M_KEY: begin
          p_ntail   = 2'd2;
          p_t0_kind = eft_pkg::K_KEY_DROP;
        end
        default: begin
          p_ntail   = 2'd1;
          p_t0_kind = eft_pkg::K_INPUT_END;
        end
      endcase
      mode_nxt = eft_pkg::M_PREKEY;
      line_nxt = LINE_ONE;
      pcnt_nxt = '0;
      ptab_nxt = '0;
      ovf_nxt  = 1'b0;
    end else begin
      case (mode_r)
        eft_pkg::M_PREKEY: begin
          if (c inside {eft_pkg::CH_SEMI, eft_pkg::CH_HASH}) begin
            mode_nxt = eft_pkg::M_COMMENT;
          end else if (!eft_pkg::is_ws(c)) begin
            mode_nxt  = eft_pkg::M_KEY;
            pcnt_nxt  = '0;
            ptab_nxt  = '0;
            p_ntail   = 2'd1;
            p_t0_kind = eft_pkg::K_KEY_CHAR;
            p_t0_char = c;
          end
        end
        eft_pkg::M_KEY, eft_pkg::M_VAL: begin
          if (eft_pkg::is_nl(c)) begin
            // close the pair or drop the key, then next line
            p_ntail   = 2'd1;
            p_t0_kind = (mode_r == eft_pkg::M_KEY) ? eft_pkg::K_KEY_DROP
                                                   : eft_pkg::K_PAIR_END;
            ovf_nxt   = 1'b0;
            mode_nxt  = eft_pkg::M_PREKEY;
            line_nxt  = line_inc;
            pcnt_nxt  = '0;
            ptab_nxt  = '0;
          end else if (mode_r == eft_pkg::M_KEY && c == eft_pkg::CH_EQUAL) begin
            pcnt_nxt = '0;
            ptab_nxt = '0;
            mode_nxt = eft_pkg::M_PREVAL;
          end else if (mode_r == eft_pkg::M_VAL && c == eft_pkg::CH_BSLASH) begin
            p_flush  = 1'b1;
            p_fkind  = eft_pkg::K_VAL_CHAR;
            pcnt_nxt = '0;
            ptab_nxt = '0;
            mode_nxt = eft_pkg::M_VALESC;
          end else if (eft_pkg::is_ws(c)) begin
            // hold the whitespace, or drop it when the store is full
            if (pcnt_r < PMAX) begin
              if (c == eft_pkg::CH_TAB) begin
                ptab_nxt = ptab_r |
                  (PENDING_WS_MAX'(1) << pcnt_r);
              end
              pcnt_nxt = pcnt_r + PCW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            p_flush   = 1'b1;
            p_fkind   = (mode_r == eft_pkg::M_KEY) ? eft_pkg::K_KEY_CHAR
                                                   : eft_pkg::K_VAL_CHAR;
            pcnt_nxt  = '0;
            ptab_nxt  = '0;
            p_ntail   = 2'd1;
            p_t0_kind = p_fkind;
            p_t0_char = c;
          end
        end
        eft_pkg::M_PREVAL: begin
          if (eft_pkg::is_nl(c)) begin
            p_ntail   = 2'd1;
            p_t0_kind = eft_pkg::K_PAIR_END;
            ovf_nxt   = 1'b0;
            mode_nxt  = eft_pkg::M_PREKEY;
            line_nxt  = line_inc;
            pcnt_nxt  = '0;
            ptab_nxt  = '0;
          end else if (c == eft_pkg::CH_SQUOTE) begin
            mode_nxt = eft_pkg::M_SQ;
          end else if (c == eft_pkg::CH_DQUOTE) begin
            mode_nxt = eft_pkg::M_DQ;
          end else if (c == eft_pkg::CH_BSLASH) begin
            mode_nxt = eft_pkg::M_VALESC;
          end else if (!eft_pkg::is_ws(c)) begin
            mode_nxt  = eft_pkg::M_VAL;
            p_ntail   = 2'd1;
            p_t0_kind = eft_pkg::K_VAL_CHAR;
            p_t0_char = c;
          end
        end
        eft_pkg::M_VALESC: begin
          // escaped newline is swallowed without a line advance
          mode_nxt = eft_pkg::M_VAL;
          if (!eft_pkg::is_nl(c)) begin
            p_ntail   = 2'd1;
            p_t0_kind = eft_pkg::K_VAL_CHAR;
            p_t0_char = c;
          end
        end
        eft_pkg::M_SQ: begin
          if (c == eft_pkg::CH_SQUOTE) begin
            mode_nxt = eft_pkg::M_PREVAL;
          end else begin
            p_ntail   = 2'd1;
            p_t0_kind = eft_pkg::K_VAL_CHAR;
            p_t0_char = c;
          end
        end
        eft_pkg::M_DQ: begin
          if (c == eft_pkg::CH_DQUOTE) begin
            mode_nxt = eft_pkg::M_PREVAL;
          end else if (c == eft_pkg::CH_BSLASH) begin
            mode_nxt = eft_pkg::M_DQESC;
          end else begin
            p_ntail   = 2'd1;
            p_t0_kind = eft_pkg::K_VAL_CHAR;
            p_t0_char = c;
          end
        end
        eft_pkg::M_DQESC: begin
          // known escapes lose the backslash, an escaped line feed is swallowed, others keep it
          mode_nxt  = eft_pkg::M_DQ;
          p_t0_kind = eft_pkg::K_VAL_CHAR;
          p_t1_kind = eft_pkg::K_VAL_CHAR;
          if (c inside {eft_pkg::CH_DOLLAR, eft_pkg::CH_BTICK,
                        eft_pkg::CH_DQUOTE, eft_pkg::CH_BSLASH}) begin
            p_ntail   = 2'd1;
            p_t0_char = c;
          end else if (c != eft_pkg::CH_LF) begin
            p_ntail   = 2'd2;
            p_t0_char = eft_pkg::CH_BSLASH;
            p_t1_char = c;
          end
        end
        eft_pkg::M_COMMENT: begin
          if (c == eft_pkg::CH_BSLASH) begin
            mode_nxt = eft_pkg::M_COMMESC;
          end else if (eft_pkg::is_nl(c)) begin
            mode_nxt = eft_pkg::M_PREKEY;
            line_nxt = line_inc;
            pcnt_nxt = '0;
            ptab_nxt = '0;
          end
        end
        eft_pkg::M_COMMESC: begin
          if (eft_pkg::is_nl(c)) begin
            mode_nxt = eft_pkg::M_PREKEY;
            line_nxt = line_inc;
            pcnt_nxt = '0;
            ptab_nxt = '0;
          end else begin
            mode_nxt = eft_pkg::M_COMMENT;
          end
        end
        default: begin
          mode_nxt = eft_pkg::M_PREKEY;
        end
      endcase
    end
  end

  // status to the controller
  always_comb begin
    sts.plan_flush = p_flush && (pcnt_r != '0);
    sts.plan_tail  = (p_ntail != 2'd0);
    sts.fcnt_one   = (fcnt_r == PCW'(1));
    sts.tail_nz    = (ntail_r != 2'd0);
    sts.tail_two   = (ntail_r == 2'd2);
    sts.out_free   = out_free;
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= eft_pkg::M_PREKEY;
      line_r <= LINE_ONE;
      pcnt_r <= '0;
      ptab_r <= '0;
      ovf_r  <= 1'b0;
    end else if (cmd.load) begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
      pcnt_r <= pcnt_nxt;
      ptab_r <= ptab_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  // plan latch and flush shifter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcnt_r  <= '0;
      ntail_r <= 2'd0;
    end else if (cmd.load) begin
      fcnt_r  <= p_flush ? pcnt_r : '0;
      ntail_r <= p_ntail;
    end else if (cmd.emit && cmd.sel == eft_pkg::SEL_FLUSH) begin
      fcnt_r  <= fcnt_r - PCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      snap_line_r <= line_r;
      snap_ovf_r  <= ovf_r;
      ftab_r      <= ptab_r;
      fkind_r     <= p_fkind;
      t0_kind_r   <= p_t0_kind;
      t0_char_r   <= p_t0_char;
      t0_ovf_r    <= ovf_r;
      t1_kind_r   <= p_t1_kind;
      t1_char_r   <= p_t1_char;
      t1_ovf_r    <= p_t1_ovf;
    end else if (cmd.emit && cmd.sel == eft_pkg::SEL_FLUSH) begin
      ftab_r <= ftab_r >> 1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_line_r <= snap_line_r;
      case (cmd.sel)
        eft_pkg::SEL_FLUSH: begin
          o_kind_r <= fkind_r;
          o_char_r <= ftab_r[0] ? eft_pkg::CH_TAB : eft_pkg::CH_SPACE;
          o_ovf_r  <= snap_ovf_r;
          o_last_r <= (fcnt_r == PCW'(1)) && (ntail_r == 2'd0);
        end
        eft_pkg::SEL_T0: begin
          o_kind_r <= t0_kind_r;
          o_char_r <= t0_char_r;
          o_ovf_r  <= t0_ovf_r;
          o_last_r <= (ntail_r == 2'd1);
        end
        default: begin
          o_kind_r <= t1_kind_r;
          o_char_r <= t1_char_r;
          o_ovf_r  <= t1_ovf_r;
          o_last_r <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = o_kind_r;
  assign out_char        = o_char_r;
  assign out_line_number = eft_pkg::LINE_OUT_W'(o_line_r);
  assign out_ws_overflow = o_ovf_r;
  assign out_last        = o_last_r;

endmodule

`default_nettype wire

// ----- sv/eft_checker.sv -----
// ----------------------------------------------------------------------------
// eft_checker: port-level checks for the env file tokenizer
// Watches the result channel for stall behavior and word consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module eft_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_kind,
  input wire logic [7:0]  out_char,
  input wire logic [15:0] out_line_number,
  input wire logic        out_ws_overflow,
  input wire logic        out_last
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_char)
      && $stable(out_line_number) && $stable(out_last))
    else $error("result word changed under stall");

  // markers carry no character
  a_marker_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != eft_pkg::K_KEY_CHAR && out_kind != eft_pkg::K_VAL_CHAR
      |-> out_char == eft_pkg::CH_NUL)
    else $error("marker word with nonzero character");

  // input end is always the final word of its input
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == eft_pkg::K_INPUT_END |-> out_last && !out_ws_overflow)
    else $error("input end not last or with overflow flag");

  // line numbering restarts at one after input end
  a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_kind == eft_pkg::K_INPUT_END
      |=> !out_valid || out_line_number == 16'd1 || out_kind == eft_pkg::K_INPUT_END)
    else $error("line number not restarted after input end");

endmodule

bind env_file_tokenizer eft_checker u_eft_checker (.*);

`default_nettype wire
